>>> rtl/core/i2c_register_transfer_sequencer_macros.svh
// Assertion macros shared by the register transfer sequencer RTL
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, suspended while rst_ni is low
`define I2CRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, suspended while rst_ni is low
`define I2CRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/i2crts_pkg.sv
// Types, codes and constants of the I2C register transfer sequencer
`default_nettype none

package i2crts_pkg;

  // Commands carried by an input transaction
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_EVENT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_ADDR    = 4'd2,
    PH_REG     = 4'd3,
    PH_RESTART = 4'd4,
    PH_RADDR   = 4'd5,
    PH_RXEN    = 4'd6,
    PH_ACKED   = 4'd7,
    PH_NACKED  = 4'd8,
    PH_STOP    = 4'd9,
    PH_WDATA   = 4'd10
  } phase_e;

  // Bus actions requested from the byte engine
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_RXEN    = 3'd4,
    ACT_ACK     = 3'd5,
    ACT_NACK    = 3'd6,
    ACT_STOP    = 3'd7
  } action_e;

  // Error codes
  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_START_COLL    = 4'd1;
  localparam logic [3:0] ERR_ADDR_COLL     = 4'd2;
  localparam logic [3:0] ERR_ADDR_NACK     = 4'd3;
  localparam logic [3:0] ERR_REG_COLL      = 4'd4;
  localparam logic [3:0] ERR_REG_NACK      = 4'd5;
  localparam logic [3:0] ERR_RESTART_COLL  = 4'd6;
  localparam logic [3:0] ERR_RADDR_COLL    = 4'd7;
  localparam logic [3:0] ERR_RADDR_NACK    = 4'd8;
  localparam logic [3:0] ERR_RX_OVF        = 4'd9;
  localparam logic [3:0] ERR_RX_MISSING    = 4'd10;
  localparam logic [3:0] ERR_RX_REEN_OVF   = 4'd11;
  localparam logic [3:0] ERR_WFIRST_COLL   = 4'd12;
  localparam logic [3:0] ERR_WDATA_COLL    = 4'd13;
  localparam logic [3:0] ERR_WDATA_NACK    = 4'd14;

  // Direction bit appended to the device address
  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  // One input transaction
  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  device_address;
    logic [7:0]  register_address;
    logic [15:0] length;
    logic        acked;
    logic        collision;
    logic        overflow;
    logic        rx_available;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_t;

  // Sequencer state
  typedef struct packed {
    phase_e      phase;
    logic        is_read;
    logic [6:0]  target_address;
    logic [7:0]  target_register;
    logic [15:0] bytes_left;
  } state_t;

  // One result transaction
  typedef struct packed {
    action_e     action;
    logic [7:0]  action_byte;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        done_res;
    logic [3:0]  error_code;
    logic [15:0] remaining;
    logic        rejected;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/i2crts_step.sv
// Next-state and result logic for one sequencer transaction
`default_nettype none

module i2crts_step (
  input  var i2crts_pkg::in_t    item_i,
  input  var i2crts_pkg::state_t state_i,
  output i2crts_pkg::state_t     state_o,
  output i2crts_pkg::res_t       res_o
);

  i2crts_pkg::phase_e ph_eff;
  i2crts_pkg::state_t st;
  i2crts_pkg::res_t   res;
  logic [15:0]        left_dec;
  logic               fail;
  logic [3:0]         fail_code;

  assign left_dec = state_i.bytes_left - 16'd1;

  // Treat unused phase codes as idle
  always_comb begin
    if (state_i.phase > i2crts_pkg::PH_WDATA) begin
      ph_eff = i2crts_pkg::PH_IDLE;
    end else begin
      ph_eff = state_i.phase;
    end
  end

  // Decode the command against the current phase
  always_comb begin
    st          = state_i;
    st.phase    = ph_eff;
    res         = '0;
    res.action  = i2crts_pkg::ACT_NONE;
    fail        = 1'b0;
    fail_code   = i2crts_pkg::ERR_NONE;

    unique case (item_i.command)
      i2crts_pkg::CMD_READ, i2crts_pkg::CMD_WRITE: begin
        if (ph_eff != i2crts_pkg::PH_IDLE) begin
          res.rejected = 1'b1;
        end else begin
          st.is_read         = (item_i.command == i2crts_pkg::CMD_READ);
          st.target_address  = item_i.device_address;
          st.target_register = item_i.register_address;
          st.bytes_left      = item_i.length;
          if (item_i.length == 16'd0) begin
            res.done_res = 1'b1;
          end else begin
            res.action = i2crts_pkg::ACT_START;
            st.phase   = i2crts_pkg::PH_START;
            fail       = item_i.collision;
            fail_code  = i2crts_pkg::ERR_START_COLL;
          end
        end
      end
      i2crts_pkg::CMD_EVENT: begin
        unique case (ph_eff)
          i2crts_pkg::PH_START: begin
            res.action      = i2crts_pkg::ACT_SEND;
            res.action_byte = {state_i.target_address, i2crts_pkg::RW_WRITE};
            st.phase        = i2crts_pkg::PH_ADDR;
            fail            = item_i.collision;
            fail_code       = i2crts_pkg::ERR_ADDR_COLL;
          end
          i2crts_pkg::PH_ADDR: begin
            if (!item_i.acked) begin
              fail      = 1'b1;
              fail_code = i2crts_pkg::ERR_ADDR_NACK;
            end else begin
              res.action      = i2crts_pkg::ACT_SEND;
              res.action_byte = state_i.target_register;
              st.phase        = i2crts_pkg::PH_REG;
              fail            = item_i.collision;
              fail_code       = i2crts_pkg::ERR_REG_COLL;
            end
          end
          i2crts_pkg::PH_REG: begin
            if (!item_i.acked) begin
              fail      = 1'b1;
              fail_code = i2crts_pkg::ERR_REG_NACK;
            end else if (state_i.is_read) begin
              res.action = i2crts_pkg::ACT_RESTART;
              st.phase   = i2crts_pkg::PH_RESTART;
              fail       = item_i.collision;
              fail_code  = i2crts_pkg::ERR_RESTART_COLL;
            end else begin
              st.phase = i2crts_pkg::PH_WDATA;
              if (state_i.bytes_left != 16'd0) begin
                res.action      = i2crts_pkg::ACT_SEND;
                res.action_byte = item_i.tx_byte;
                fail            = item_i.collision;
                fail_code       = i2crts_pkg::ERR_WFIRST_COLL;
                if (!item_i.collision) begin
                  st.bytes_left = left_dec;
                end
              end
            end
          end
          i2crts_pkg::PH_RESTART: begin
            if (state_i.is_read) begin
              res.action      = i2crts_pkg::ACT_SEND;
              res.action_byte = {state_i.target_address, i2crts_pkg::RW_READ};
              st.phase        = i2crts_pkg::PH_RADDR;
              fail            = item_i.collision;
              fail_code       = i2crts_pkg::ERR_RADDR_COLL;
            end
          end
          i2crts_pkg::PH_RADDR: begin
            if (!item_i.acked) begin
              fail      = 1'b1;
              fail_code = i2crts_pkg::ERR_RADDR_NACK;
            end else if (state_i.is_read) begin
              res.action = i2crts_pkg::ACT_RXEN;
              st.phase   = i2crts_pkg::PH_RXEN;
              fail       = item_i.overflow;
              fail_code  = i2crts_pkg::ERR_RX_OVF;
            end
          end
          i2crts_pkg::PH_RXEN: begin
            if (state_i.is_read) begin
              if (!item_i.rx_available) begin
                fail      = 1'b1;
                fail_code = i2crts_pkg::ERR_RX_MISSING;
              end else begin
                // Deliver the byte if one is still owed, then ACK or NACK
                if (state_i.bytes_left != 16'd0) begin
                  res.rx_valid  = 1'b1;
                  res.rx_data   = item_i.rx_byte;
                  st.bytes_left = left_dec;
                end
                if (st.bytes_left == 16'd0) begin
                  res.action = i2crts_pkg::ACT_NACK;
                  st.phase   = i2crts_pkg::PH_NACKED;
                end else begin
                  res.action = i2crts_pkg::ACT_ACK;
                  st.phase   = i2crts_pkg::PH_ACKED;
                end
              end
            end
          end
          i2crts_pkg::PH_ACKED: begin
            res.action = i2crts_pkg::ACT_RXEN;
            st.phase   = i2crts_pkg::PH_RXEN;
            fail       = item_i.overflow;
            fail_code  = i2crts_pkg::ERR_RX_REEN_OVF;
          end
          i2crts_pkg::PH_NACKED: begin
            res.action = i2crts_pkg::ACT_STOP;
            st.phase   = i2crts_pkg::PH_STOP;
          end
          i2crts_pkg::PH_STOP: begin
            st.phase     = i2crts_pkg::PH_IDLE;
            res.done_res = 1'b1;
          end
          i2crts_pkg::PH_WDATA: begin
            if (!item_i.acked) begin
              fail      = 1'b1;
              fail_code = i2crts_pkg::ERR_WDATA_NACK;
            end else if (!state_i.is_read) begin
              if (state_i.bytes_left != 16'd0) begin
                res.action      = i2crts_pkg::ACT_SEND;
                res.action_byte = item_i.tx_byte;
                fail            = item_i.collision;
                fail_code       = i2crts_pkg::ERR_WDATA_COLL;
                if (!item_i.collision) begin
                  st.bytes_left = left_dec;
                end
              end else begin
                res.action = i2crts_pkg::ACT_STOP;
                st.phase   = i2crts_pkg::PH_STOP;
              end
            end
          end
          default: begin
            // Idle: a bus event has no effect
          end
        endcase
      end
      default: begin
        // Unused command: no effect
      end
    endcase

    // Abort the transfer on any error
    if (fail) begin
      st.phase       = i2crts_pkg::PH_IDLE;
      res.done_res   = 1'b1;
      res.error_code = fail_code;
    end

    res.remaining = st.bytes_left;
  end

  assign state_o = st;
  assign res_o   = res;

endmodule

`default_nettype wire

>>> rtl/core/i2c_register_transfer_sequencer.sv
// I2C register transfer sequencer: input register, step logic, result register
//
// Steps an I2C master through a register read or write, one transaction in,
// one result out. A start command (read or write) loads device address,
// register address and byte count; each bus event from the byte engine then
// yields the next bus action (start, address, register, data, repeated start,
// receive enable, ACK/NACK, stop) and, for reads, the delivered byte. Every
// input transaction produces exactly one result. A start while busy returns
// rejected; a zero length start finishes at once. A collision on a start, restart
// or send, a missing ACK, overflow or missing receive data ends the transfer with
// done_res and a non-zero error_code. Throughput is one transaction per clock
// while the result channel is not stalled; a transaction passes through the
// input register and then the result register, with the sequencer state updated
// as a transaction moves between them. There are no configuration registers.
`default_nettype none

module i2c_register_transfer_sequencer (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  // input channel
  input  var logic        in_valid_i,
  output logic            in_ready_o,
  input  var logic [1:0]  command_i,
  input  var logic [6:0]  device_address_i,
  input  var logic [7:0]  register_address_i,
  input  var logic [15:0] length_i,
  input  var logic        acked_i,
  input  var logic        collision_i,
  input  var logic        overflow_i,
  input  var logic        rx_available_i,
  input  var logic [7:0]  rx_byte_i,
  input  var logic [7:0]  tx_byte_i,
  // result channel
  output logic            out_valid_o,
  input  var logic        out_ready_i,
  output logic [2:0]      action_o,
  output logic [7:0]      action_byte_o,
  output logic            rx_valid_o,
  output logic [7:0]      rx_data_o,
  output logic            done_res_o,
  output logic [3:0]      error_code_o,
  output logic [15:0]     remaining_o,
  output logic            rejected_o
);

  `include "i2c_register_transfer_sequencer_macros.svh"

  logic                 in_valid_q;
  i2crts_pkg::in_t      in_q;
  i2crts_pkg::in_t      in_d;
  logic                 out_valid_q;
  i2crts_pkg::res_t     res_q;
  i2crts_pkg::res_t     res_d;
  i2crts_pkg::state_t   state_q;
  i2crts_pkg::state_t   state_d;
  logic                 advance;
  logic                 accept;

  // Move a transaction into the result register when it is free or drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // Gather the input payload
  always_comb begin
    in_d.command          = command_i;
    in_d.device_address   = device_address_i;
    in_d.register_address = register_address_i;
    in_d.length           = length_i;
    in_d.acked            = acked_i;
    in_d.collision        = collision_i;
    in_d.overflow         = overflow_i;
    in_d.rx_available     = rx_available_i;
    in_d.rx_byte          = rx_byte_i;
    in_d.tx_byte          = tx_byte_i;
  end

  // Hold the input valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Capture the input payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_d;
    end
  end

  i2crts_step u_step (
    .item_i  (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Advance the sequencer state with each transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: i2crts_pkg::PH_IDLE, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Hold the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = res_q.action;
  assign action_byte_o = res_q.action_byte;
  assign rx_valid_o    = res_q.rx_valid;
  assign rx_data_o     = res_q.rx_data;
  assign done_res_o    = res_q.done_res;
  assign error_code_o  = res_q.error_code;
  assign remaining_o   = res_q.remaining;
  assign rejected_o    = res_q.rejected;

  // Checks on the sequencer logic
  `I2CRTS_ASSERT_NOW(a_err_needs_done, out_valid_q && (res_q.error_code != i2crts_pkg::ERR_NONE), res_q.done_res, "error code without done")
  `I2CRTS_ASSERT_NOW(a_reject_alone, out_valid_q && res_q.rejected, !res_q.done_res && (res_q.action == i2crts_pkg::ACT_NONE), "rejected transaction carries other results")
  `I2CRTS_ASSERT_NOW(a_rx_with_ack, out_valid_q && res_q.rx_valid, (res_q.action == i2crts_pkg::ACT_ACK) || (res_q.action == i2crts_pkg::ACT_NACK), "read byte delivered without ACK or NACK")
  `I2CRTS_ASSERT_NEXT(a_done_to_idle, advance && res_d.done_res, state_q.phase == i2crts_pkg::PH_IDLE, "sequencer not idle after completion")
  `I2CRTS_ASSERT_NOW(a_stall_only_full, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i, "input stalled with room downstream")

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the I2C register transfer sequencer
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;

  // One row of the directed table; the typed result is used when typed is set
  typedef struct {
    i2crts_pkg::in_t  stim;
    logic             typed;
    i2crts_pkg::res_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = i2crts_pkg::CMD_NONE;
  logic [6:0]  device_address_i = '0;
  logic [7:0]  register_address_i = '0;
  logic [15:0] length_i = '0;
  logic        acked_i = 1'b0;
  logic        collision_i = 1'b0;
  logic        overflow_i = 1'b0;
  logic        rx_available_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic [7:0]  tx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  action_o;
  logic [7:0]  action_byte_o;
  logic        rx_valid_o;
  logic [7:0]  rx_data_o;
  logic        done_res_o;
  logic [3:0]  error_code_o;
  logic [15:0] remaining_o;
  logic        rejected_o;

  // Shadow of the sequencer state
  i2crts_pkg::phase_e seq_phase = i2crts_pkg::PH_IDLE;
  logic        seq_is_read = 1'b0;
  logic [6:0]  seq_addr = '0;
  logic [7:0]  seq_reg = '0;
  logic [15:0] seq_left = '0;

  i2crts_pkg::res_t pending_q[$];
  dir_row_t    dir_table[25];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          checked_count = 0;
  int          sent_count = 0;
  int          completed_count = 0;
  int          aborted_count = 0;
  int          refused_count = 0;
  int          cycle_count = 0;
  logic [15:0] codes_seen = '0;

  i2c_register_transfer_sequencer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .device_address_i   (device_address_i),
    .register_address_i (register_address_i),
    .length_i           (length_i),
    .acked_i            (acked_i),
    .collision_i        (collision_i),
    .overflow_i         (overflow_i),
    .rx_available_i     (rx_available_i),
    .rx_byte_i          (rx_byte_i),
    .tx_byte_i          (tx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .action_o           (action_o),
    .action_byte_o      (action_byte_o),
    .rx_valid_o         (rx_valid_o),
    .rx_data_o          (rx_data_o),
    .done_res_o         (done_res_o),
    .error_code_o       (error_code_o),
    .remaining_o        (remaining_o),
    .rejected_o         (rejected_o)
  );

  // Toggle the clock, 12 ns period
  always #6 clk_i = ~clk_i;

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic i2crts_pkg::in_t mk_start(i2crts_pkg::cmd_e c, logic [6:0] dev,
                                               logic [7:0] rg, logic [15:0] len,
                                               logic coll);
    i2crts_pkg::in_t it;
    it = '0;
    it.command = c;
    it.device_address = dev;
    it.register_address = rg;
    it.length = len;
    it.collision = coll;
    return it;
  endfunction

  function automatic i2crts_pkg::in_t mk_event(logic ack, logic coll, logic ovf,
                                               logic rxav, logic [7:0] rxb,
                                               logic [7:0] txb);
    i2crts_pkg::in_t it;
    it = '0;
    it.command = i2crts_pkg::CMD_EVENT;
    it.acked = ack;
    it.collision = coll;
    it.overflow = ovf;
    it.rx_available = rxav;
    it.rx_byte = rxb;
    it.tx_byte = txb;
    return it;
  endfunction

  function automatic i2crts_pkg::res_t mk_res(i2crts_pkg::action_e a, logic [7:0] b,
                                              logic done, logic [3:0] err,
                                              logic [15:0] rem, logic rej);
    i2crts_pkg::res_t r;
    r = '0;
    r.action = a;
    r.action_byte = b;
    r.done_res = done;
    r.error_code = err;
    r.remaining = rem;
    r.rejected = rej;
    return r;
  endfunction

  function automatic string fmt_res(i2crts_pkg::res_t r);
    return $sformatf("act=%0d byte=%02h rxv=%0b rxd=%02h done=%0b err=%0d rem=%0d rej=%0b",
                     r.action, r.action_byte, r.rx_valid, r.rx_data, r.done_res,
                     r.error_code, r.remaining, r.rejected);
  endfunction

  // Advance the shadow sequencer by one transaction and return its result
  function automatic i2crts_pkg::res_t advance_sequencer(i2crts_pkg::in_t it);
    i2crts_pkg::res_t r;
    logic [3:0]       err;
    r = '0;
    r.action = i2crts_pkg::ACT_NONE;
    err = i2crts_pkg::ERR_NONE;
    case (it.command)
      i2crts_pkg::CMD_READ, i2crts_pkg::CMD_WRITE: begin
        if (seq_phase != i2crts_pkg::PH_IDLE) begin
          r.rejected = 1'b1;
        end else begin
          seq_is_read = (it.command == i2crts_pkg::CMD_READ);
          seq_addr = it.device_address;
          seq_reg = it.register_address;
          seq_left = it.length;
          if (seq_left == 16'd0) begin
            r.done_res = 1'b1;
          end else begin
            r.action = i2crts_pkg::ACT_START;
            seq_phase = i2crts_pkg::PH_START;
            if (it.collision) err = i2crts_pkg::ERR_START_COLL;
          end
        end
      end
      i2crts_pkg::CMD_EVENT: begin
        case (seq_phase)
          i2crts_pkg::PH_START: begin
            r.action = i2crts_pkg::ACT_SEND;
            r.action_byte = {seq_addr, i2crts_pkg::RW_WRITE};
            if (it.collision) err = i2crts_pkg::ERR_ADDR_COLL;
            else seq_phase = i2crts_pkg::PH_ADDR;
          end
          i2crts_pkg::PH_ADDR: begin
            if (!it.acked) begin
              err = i2crts_pkg::ERR_ADDR_NACK;
            end else begin
              r.action = i2crts_pkg::ACT_SEND;
              r.action_byte = seq_reg;
              if (it.collision) err = i2crts_pkg::ERR_REG_COLL;
              else seq_phase = i2crts_pkg::PH_REG;
            end
          end
          i2crts_pkg::PH_REG: begin
            if (!it.acked) begin
              err = i2crts_pkg::ERR_REG_NACK;
            end else if (seq_is_read) begin
              r.action = i2crts_pkg::ACT_RESTART;
              if (it.collision) err = i2crts_pkg::ERR_RESTART_COLL;
              else seq_phase = i2crts_pkg::PH_RESTART;
            end else begin
              seq_phase = i2crts_pkg::PH_WDATA;
              if (seq_left != 16'd0) begin
                r.action = i2crts_pkg::ACT_SEND;
                r.action_byte = it.tx_byte;
                if (it.collision) err = i2crts_pkg::ERR_WFIRST_COLL;
                else seq_left = seq_left - 16'd1;
              end
            end
          end
          i2crts_pkg::PH_RESTART: begin
            if (seq_is_read) begin
              r.action = i2crts_pkg::ACT_SEND;
              r.action_byte = {seq_addr, i2crts_pkg::RW_READ};
              if (it.collision) err = i2crts_pkg::ERR_RADDR_COLL;
              else seq_phase = i2crts_pkg::PH_RADDR;
            end
          end
          i2crts_pkg::PH_RADDR: begin
            if (!it.acked) begin
              err = i2crts_pkg::ERR_RADDR_NACK;
            end else if (seq_is_read) begin
              r.action = i2crts_pkg::ACT_RXEN;
              if (it.overflow) err = i2crts_pkg::ERR_RX_OVF;
              else seq_phase = i2crts_pkg::PH_RXEN;
            end
          end
          i2crts_pkg::PH_RXEN: begin
            if (seq_is_read) begin
              if (!it.rx_available) begin
                err = i2crts_pkg::ERR_RX_MISSING;
              end else begin
                if (seq_left != 16'd0) begin
                  r.rx_valid = 1'b1;
                  r.rx_data = it.rx_byte;
                  seq_left = seq_left - 16'd1;
                end
                // NACK the last byte, ACK the others
                if (seq_left == 16'd0) begin
                  r.action = i2crts_pkg::ACT_NACK;
                  seq_phase = i2crts_pkg::PH_NACKED;
                end else begin
                  r.action = i2crts_pkg::ACT_ACK;
                  seq_phase = i2crts_pkg::PH_ACKED;
                end
              end
            end
          end
          i2crts_pkg::PH_ACKED: begin
            r.action = i2crts_pkg::ACT_RXEN;
            if (it.overflow) err = i2crts_pkg::ERR_RX_REEN_OVF;
            else seq_phase = i2crts_pkg::PH_RXEN;
          end
          i2crts_pkg::PH_NACKED: begin
            r.action = i2crts_pkg::ACT_STOP;
            seq_phase = i2crts_pkg::PH_STOP;
          end
          i2crts_pkg::PH_STOP: begin
            seq_phase = i2crts_pkg::PH_IDLE;
            r.done_res = 1'b1;
          end
          i2crts_pkg::PH_WDATA: begin
            if (!it.acked) begin
              err = i2crts_pkg::ERR_WDATA_NACK;
            end else if (!seq_is_read) begin
              if (seq_left != 16'd0) begin
                r.action = i2crts_pkg::ACT_SEND;
                r.action_byte = it.tx_byte;
                if (it.collision) err = i2crts_pkg::ERR_WDATA_COLL;
                else seq_left = seq_left - 16'd1;
              end else begin
                r.action = i2crts_pkg::ACT_STOP;
                seq_phase = i2crts_pkg::PH_STOP;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // Drop back to idle on any error, keeping the action already issued
    if (err != i2crts_pkg::ERR_NONE) begin
      seq_phase = i2crts_pkg::PH_IDLE;
      r.done_res = 1'b1;
      r.error_code = err;
    end
    r.remaining = seq_left;
    return r;
  endfunction

  // Pick the next random transaction, mostly well-formed for the current phase
  function automatic i2crts_pkg::in_t next_random_item();
    i2crts_pkg::in_t it;
    int              pick;
    int              len_pick;
    it.device_address = 7'($urandom);
    it.register_address = 8'($urandom);
    it.length = 16'($urandom);
    it.rx_byte = 8'($urandom);
    it.tx_byte = 8'($urandom);
    it.acked = ($urandom_range(99) < 94);
    it.collision = ($urandom_range(99) < 4);
    it.overflow = ($urandom_range(99) < 4);
    it.rx_available = ($urandom_range(99) < 94);
    pick = $urandom_range(99);
    if (seq_phase == i2crts_pkg::PH_IDLE) begin
      if (pick < 85) begin
        it.command = $urandom_range(1) ? i2crts_pkg::CMD_READ : i2crts_pkg::CMD_WRITE;
        // Keep transfers short, with a few empty and a few of any length
        len_pick = $urandom_range(99);
        if (len_pick < 8) it.length = 16'd0;
        else if (len_pick < 75) it.length = 16'($urandom_range(4, 1));
        else if (len_pick < 95) it.length = 16'($urandom_range(20, 5));
      end else if (pick < 93) begin
        it.command = i2crts_pkg::CMD_EVENT;
      end else begin
        it.command = i2crts_pkg::CMD_NONE;
      end
    end else begin
      if (pick < 4) it.command = $urandom_range(1) ? i2crts_pkg::CMD_READ
                                                   : i2crts_pkg::CMD_WRITE;
      else if (pick < 7) it.command = i2crts_pkg::CMD_NONE;
      else it.command = i2crts_pkg::CMD_EVENT;
    end
    return it;
  endfunction

  // Present one transaction, with random idle cycles before it
  task automatic send_transaction(i2crts_pkg::in_t it, logic typed,
                                  i2crts_pkg::res_t typed_res);
    i2crts_pkg::res_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= it.command;
    device_address_i <= it.device_address;
    register_address_i <= it.register_address;
    length_i <= it.length;
    acked_i <= it.acked;
    collision_i <= it.collision;
    overflow_i <= it.overflow;
    rx_available_i <= it.rx_available;
    rx_byte_i <= it.rx_byte;
    tx_byte_i <= it.tx_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Accepted at this edge: queue the expected result
    pred = advance_sequencer(it);
    pending_q.push_back(typed ? typed_res : pred);
    sent_count++;
    if (pred.rejected) refused_count++;
    if (pred.done_res && pred.error_code == i2crts_pkg::ERR_NONE) completed_count++;
    if (pred.error_code != i2crts_pkg::ERR_NONE) aborted_count++;
    codes_seen[pred.error_code] = 1'b1;
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    i2crts_pkg::res_t got;
    i2crts_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.action = i2crts_pkg::action_e'(action_o);
      got.action_byte = action_byte_o;
      got.rx_valid = rx_valid_o;
      got.rx_data = rx_data_o;
      got.done_res = done_res_o;
      got.error_code = error_code_o;
      got.remaining = remaining_o;
      got.rejected = rejected_o;
      if (pending_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with no transaction waiting: %s", $realtime, fmt_res(got));
      end else begin
        want = pending_q.pop_front();
        checked_count++;
        if (got.action != want.action || got.action_byte != want.action_byte ||
            got.rx_valid != want.rx_valid || got.rx_data != want.rx_data ||
            got.done_res != want.done_res || got.error_code != want.error_code ||
            got.remaining != want.remaining || got.rejected != want.rejected) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch on result %0d", $realtime, checked_count);
            $display("  expected %s", fmt_res(want));
            $display("  actual   %s", fmt_res(got));
          end
        end
      end
    end
  end

  initial begin
    i2crts_pkg::in_t it;
    int              counted;
    int              ph;

    // Directed: idle and ignored inputs, empty start, start collision,
    // a one-byte write with a refused start, a two-byte read, address NACK
    dir_table[0]  = '{mk_event(1'b1, 1'b1, 1'b1, 1'b1, 8'hff, 8'hff), 1'b1,
                      mk_res(i2crts_pkg::ACT_NONE, 8'h00, 1'b0, i2crts_pkg::ERR_NONE,
                             16'd0, 1'b0)};
    dir_table[1]  = '{mk_start(i2crts_pkg::CMD_NONE, 7'h7f, 8'hff, 16'hffff, 1'b1), 1'b1,
                      mk_res(i2crts_pkg::ACT_NONE, 8'h00, 1'b0, i2crts_pkg::ERR_NONE,
                             16'd0, 1'b0)};
    dir_table[2]  = '{mk_start(i2crts_pkg::CMD_WRITE, 7'h00, 8'h00, 16'd0, 1'b1), 1'b1,
                      mk_res(i2crts_pkg::ACT_NONE, 8'h00, 1'b1, i2crts_pkg::ERR_NONE,
                             16'd0, 1'b0)};
    dir_table[3]  = '{mk_start(i2crts_pkg::CMD_READ, 7'h7f, 8'hff, 16'hffff, 1'b1), 1'b1,
                      mk_res(i2crts_pkg::ACT_START, 8'h00, 1'b1,
                             i2crts_pkg::ERR_START_COLL, 16'hffff, 1'b0)};
    dir_table[4]  = '{mk_start(i2crts_pkg::CMD_WRITE, 7'h7f, 8'hff, 16'd1, 1'b0), 1'b0,
                      '0};
    dir_table[5]  = '{mk_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b1,
                      mk_res(i2crts_pkg::ACT_SEND, 8'hfe, 1'b0, i2crts_pkg::ERR_NONE,
                             16'd1, 1'b0)};
    dir_table[6]  = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[7]  = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'hff), 1'b0, '0};
    dir_table[8]  = '{mk_start(i2crts_pkg::CMD_READ, 7'h00, 8'h00, 16'd5, 1'b0), 1'b1,
                      mk_res(i2crts_pkg::ACT_NONE, 8'h00, 1'b0, i2crts_pkg::ERR_NONE,
                             16'd0, 1'b1)};
    dir_table[9]  = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[10] = '{mk_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[11] = '{mk_start(i2crts_pkg::CMD_READ, 7'h00, 8'h00, 16'd2, 1'b0), 1'b0,
                      '0};
    dir_table[12] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[13] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[14] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[15] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[16] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[17] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00), 1'b0, '0};
    dir_table[18] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[19] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b1, 8'hff, 8'h00), 1'b0, '0};
    dir_table[20] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[21] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[22] = '{mk_start(i2crts_pkg::CMD_WRITE, 7'h55, 8'haa, 16'd3, 1'b0), 1'b0,
                      '0};
    dir_table[23] = '{mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, '0};
    dir_table[24] = '{mk_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00), 1'b1,
                      mk_res(i2crts_pkg::ACT_NONE, 8'h00, 1'b1,
                             i2crts_pkg::ERR_ADDR_NACK, 16'd3, 1'b0)};

    // Hold reset, then release it
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) send_transaction(dir_table[i].stim, dir_table[i].typed,
                                            dir_table[i].res);

    // Random: four pacing phases, ignored inputs not counted
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      counted = 0;
      while (counted < RANDOM_ITEMS / 4) begin
        it = next_random_item();
        if (!(it.command == i2crts_pkg::CMD_NONE ||
              (it.command == i2crts_pkg::CMD_EVENT && seq_phase == i2crts_pkg::PH_IDLE)))
          counted++;
        send_transaction(it, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d transactions, checked %0d results, %0d mismatches",
             sent_count, checked_count, mismatch_count);
    $display("Transfers completed %0d, aborted %0d, starts refused %0d, error codes hit %b",
             completed_count, aborted_count, refused_count, codes_seen[14:1]);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
